// ===== src/rwl_pkg.sv =====
// shared types and constants of the reader-writer lock arbiter
package rwl_pkg;

   localparam int ID_W      = 4;
   localparam int READERS_W = 5;

   localparam logic [READERS_W-1:0] READERS_MAX = 5'd31;

   typedef enum logic [1:0] {
      REQ_START_READ  = 2'd0,
      REQ_END_READ    = 2'd1,
      REQ_START_WRITE = 2'd2,
      REQ_END_WRITE   = 2'd3
   } req_kind_type;

   typedef enum logic {
      KIND_READ  = 1'b0,
      KIND_WRITE = 1'b1
   } grant_kind_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ_REL,
      S_WRITE_GRANT
   } state_type;

   // queue commands from the sequencer
   typedef struct packed {
      logic            push;
      logic [ID_W-1:0] push_id;
      logic            pop;
      logic            rd;
   } qctl_type;

   // queue occupancy flags back to the sequencer
   typedef struct packed {
      logic empty;
      logic single;
      logic full;
   } qsts_type;

endpackage

// ===== src/reader_writer_lock_arbiter.sv =====
// top level of the reader-priority reader-writer lock arbiter
//
//  channel | ports                                          | dir
//  --------+------------------------------------------------+-----
//  req     | req_valid req_stall req_type req_requester_id  | in
//  rsp     | rsp_valid rsp_stall rsp_granted rsp_grant_id   | out
//          | rsp_grant_kind rsp_last_result                 |
//
//  a request that grants at most its own agent needs no queue read; its beat
//  sits in the output register from the next cycle on
//  a reader release or a head writer grant first reads the queue ram, then
//  gives one grant beat per cycle while the output is not stalled; no request
//  is taken while a release runs
//  reset clears counts, flags and queue pointers; the queue rams need no
//  clearing pass since only written entries are ever read
//  a stalled result holds the sequencer; a new request is taken in the
//  cycle the pending result beat leaves
module reader_writer_lock_arbiter
   import rwl_pkg::*;
#(
   parameter int AGENT_COUNT = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [1:0]      req_type,
   input  logic [ID_W-1:0] req_requester_id,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic            rsp_granted,
   output logic [ID_W-1:0] rsp_grant_id,
   output logic            rsp_grant_kind,
   output logic            rsp_last_result
);

   state_type state_ff, state_in;

   logic [READERS_W-1:0] active_readers_ff, active_readers_in;
   logic                 writer_active_ff, writer_active_in;
   logic [READERS_W-1:0] readers_inc;

   // output register
   logic            rsp_valid_ff;
   logic            granted_ff, granted_in;
   logic [ID_W-1:0] grant_id_ff, grant_id_in;
   logic            grant_kind_ff, grant_kind_in;
   logic            last_ff, last_in;
   logic            emit;
   logic            out_free;
   logic            accept;

   qctl_type        rq_ctl, wq_ctl;
   qsts_type        rq_sts, wq_sts;
   logic [ID_W-1:0] rq_head, wq_head;

   req_kind_type    req_kind;

   assign req_kind    = req_kind_type'(req_type);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign accept      = req_valid && !req_stall;
   // active reader count saturates
   assign readers_inc = (active_readers_ff == READERS_MAX) ? active_readers_ff
                                                          : active_readers_ff + 1'b1;

   // waiting readers
   rwl_queue #(
      .DEPTH(AGENT_COUNT)
   ) u_reader_q (
      .clock  (clock),
      .reset  (reset),
      .ctl    (rq_ctl),
      .sts    (rq_sts),
      .head_id(rq_head)
   );

   // waiting writers
   rwl_queue #(
      .DEPTH(AGENT_COUNT)
   ) u_writer_q (
      .clock  (clock),
      .reset  (reset),
      .ctl    (wq_ctl),
      .sts    (wq_sts),
      .head_id(wq_head)
   );

   // sequencer outputs and state updates
   always_comb begin
      req_stall         = 1'b1;
      rq_ctl            = '0;
      wq_ctl            = '0;
      rq_ctl.push_id    = req_requester_id;
      wq_ctl.push_id    = req_requester_id;
      active_readers_in = active_readers_ff;
      writer_active_in  = writer_active_ff;
      emit              = 1'b0;
      granted_in        = 1'b0;
      grant_id_in       = '0;
      grant_kind_in     = KIND_READ;
      last_in           = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            req_stall = !out_free;
            if (accept) begin
               unique case (req_kind)
                  REQ_START_READ: begin
                     if (writer_active_ff) begin
                        // wait behind the writer, dropped when queue is full
                        rq_ctl.push = 1'b1;
                        emit        = 1'b1;
                     end else begin
                        active_readers_in = readers_inc;
                        emit              = 1'b1;
                        granted_in        = 1'b1;
                        grant_id_in       = req_requester_id;
                        grant_kind_in     = KIND_READ;
                        // any waiting readers follow this grant
                        last_in           = rq_sts.empty;
                        rq_ctl.rd         = !rq_sts.empty;
                     end
                  end
                  REQ_END_READ: begin
                     if (active_readers_ff != '0) begin
                        active_readers_in = active_readers_ff - 1'b1;
                        // last reader out hands over to the head writer
                        if (active_readers_ff == READERS_W'(1) && !writer_active_ff &&
                            !wq_sts.empty) begin
                           wq_ctl.rd = 1'b1;
                        end else begin
                           emit = 1'b1;
                        end
                     end else begin
                        emit = 1'b1;
                     end
                  end
                  REQ_START_WRITE: begin
                     if (active_readers_ff != '0 || writer_active_ff) begin
                        wq_ctl.push = 1'b1;
                        emit        = 1'b1;
                     end else begin
                        writer_active_in = 1'b1;
                        emit             = 1'b1;
                        granted_in       = 1'b1;
                        grant_id_in      = req_requester_id;
                        grant_kind_in    = KIND_WRITE;
                     end
                  end
                  REQ_END_WRITE: begin
                     if (writer_active_ff) begin
                        writer_active_in = 1'b0;
                        // readers have priority over the next writer
                        if (!rq_sts.empty) begin
                           rq_ctl.rd = 1'b1;
                        end else if (!wq_sts.empty) begin
                           wq_ctl.rd = 1'b1;
                        end else begin
                           emit = 1'b1;
                        end
                     end else begin
                        emit = 1'b1;
                     end
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         S_READ_REL: begin
            // one released reader per free output slot, next head prefetched
            if (out_free) begin
               emit              = 1'b1;
               granted_in        = 1'b1;
               grant_id_in       = rq_head;
               grant_kind_in     = KIND_READ;
               last_in           = rq_sts.single;
               rq_ctl.pop        = 1'b1;
               rq_ctl.rd         = !rq_sts.single;
               active_readers_in = readers_inc;
            end
         end
         S_WRITE_GRANT: begin
            if (out_free) begin
               emit             = 1'b1;
               granted_in       = 1'b1;
               grant_id_in      = wq_head;
               grant_kind_in    = KIND_WRITE;
               wq_ctl.pop       = 1'b1;
               writer_active_in = 1'b1;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && rq_ctl.rd) begin
               state_in = S_READ_REL;
            end else if (accept && wq_ctl.rd) begin
               state_in = S_WRITE_GRANT;
            end
         end
         S_READ_REL: begin
            if (out_free && rq_sts.single) begin
               state_in = S_IDLE;
            end
         end
         S_WRITE_GRANT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         active_readers_ff <= '0;
         writer_active_ff  <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         active_readers_ff <= active_readers_in;
         writer_active_ff  <= writer_active_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, loaded only with a new beat
   always_ff @(posedge clock) begin
      if (emit) begin
         granted_ff    <= granted_in;
         grant_id_ff   <= grant_id_in;
         grant_kind_ff <= grant_kind_in;
         last_ff       <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = granted_ff;
   assign rsp_grant_id    = grant_id_ff;
   assign rsp_grant_kind  = grant_kind_ff;
   assign rsp_last_result = last_ff;

endmodule

// ===== src/rwl_ram.sv =====
// generic single-write, single-read ram with registered read data
module rwl_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/rwl_queue.sv =====
// circular fifo of waiting agent ids held in a ram
module rwl_queue
   import rwl_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  qctl_type        ctl,
   output qsts_type        sts,
   output logic [ID_W-1:0] head_id
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [PW-1:0] head_ff, head_in, head_next;
   logic [PW-1:0] tail_ff, tail_in, tail_next;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;

   assign head_next = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   assign sts.empty  = (count_ff == '0);
   assign sts.single = (count_ff == CW'(1));
   assign sts.full   = (count_ff == CW'(DEPTH));

   // a push into a full queue is dropped
   assign do_push = ctl.push && !sts.full;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in  = tail_next;
         count_in = count_ff + 1'b1;
      end
      if (ctl.pop) begin
         head_in  = head_next;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // a read that comes with a pop fetches the entry behind the head
   rwl_ram #(
      .WIDTH(ID_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (do_push),
      .wr_addr(tail_ff),
      .wr_data(ctl.push_id),
      .rd_en  (ctl.rd),
      .rd_addr(ctl.pop ? head_next : head_ff),
      .rd_data(head_id)
   );

endmodule

// ===== test/rwl_checker.sv =====
// lock grant predictor and result beat checker for the reader-writer lock arbiter
`timescale 1ns / 1ps
module rwl_checker
   import rwl_pkg::*;
#(
   parameter int AGENT_COUNT = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  logic [1:0]      req_type,
   input  logic [ID_W-1:0] req_requester_id,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  logic            rsp_granted,
   input  logic [ID_W-1:0] rsp_grant_id,
   input  logic            rsp_grant_kind,
   input  logic            rsp_last_result,
   output int              mismatches,
   output int              outstanding,
   output int              served
);

   typedef struct packed {
      logic            granted;
      logic [ID_W-1:0] id;
      grant_kind_type  kind;
      logic            last;
   } grant_beat_type;

   grant_beat_type pending_grants[$];
   grant_beat_type request_grants[$];

   logic [READERS_W-1:0] readers_active = '0;
   logic                 writer_busy = 1'b0;
   logic [ID_W-1:0]      waiting_readers[$];
   logic [ID_W-1:0]      waiting_writers[$];

   int mismatch_count = 0;
   int served_count = 0;

   function automatic void add_grant(logic [ID_W-1:0] id, grant_kind_type kind);
      request_grants.push_back('{granted: 1'b1, id: id, kind: kind, last: 1'b0});
   endfunction

   // reader count saturates
   function automatic void admit_reader(logic [ID_W-1:0] id);
      if (readers_active != READERS_MAX)
         readers_active = readers_active + 1'b1;
      add_grant(id, KIND_READ);
   endfunction

   function automatic void release_waiting_readers();
      while (waiting_readers.size() > 0)
         admit_reader(waiting_readers.pop_front());
   endfunction

   function automatic void grant_head_writer();
      writer_busy = 1'b1;
      add_grant(waiting_writers.pop_front(), KIND_WRITE);
   endfunction

   // works out the grant beats of one request and queues them
   function automatic void predict_grants(req_kind_type kind, logic [ID_W-1:0] id);
      bit acted;
      acted = 1'b1;
      request_grants.delete();
      case (kind)
         REQ_START_READ: begin
            if (writer_busy) begin
               if (waiting_readers.size() < AGENT_COUNT)
                  waiting_readers.push_back(id);
               else
                  acted = 1'b0;
            end else begin
               admit_reader(id);
               release_waiting_readers();
            end
         end
         REQ_END_READ: begin
            if (readers_active != 0) begin
               readers_active = readers_active - 1'b1;
               if (readers_active == 0 && !writer_busy && waiting_writers.size() > 0)
                  grant_head_writer();
            end else begin
               acted = 1'b0;
            end
         end
         REQ_START_WRITE: begin
            if (readers_active != 0 || writer_busy) begin
               if (waiting_writers.size() < AGENT_COUNT)
                  waiting_writers.push_back(id);
               else
                  acted = 1'b0;
            end else begin
               writer_busy = 1'b1;
               add_grant(id, KIND_WRITE);
            end
         end
         default: begin
            if (writer_busy) begin
               writer_busy = 1'b0;
               if (waiting_readers.size() > 0)
                  release_waiting_readers();
               else if (waiting_writers.size() > 0)
                  grant_head_writer();
            end else begin
               acted = 1'b0;
            end
         end
      endcase
      if (request_grants.size() == 0)
         request_grants.push_back('{granted: 1'b0, id: '0, kind: KIND_READ, last: 1'b0});
      request_grants[request_grants.size()-1].last = 1'b1;
      foreach (request_grants[i])
         pending_grants.push_back(request_grants[i]);
      if (acted)
         served_count++;
   endfunction

   always @(posedge clock) begin
      grant_beat_type seen;
      grant_beat_type want;
      if (reset) begin
         readers_active = '0;
         writer_busy = 1'b0;
         waiting_readers.delete();
         waiting_writers.delete();
         pending_grants.delete();
      end else begin
         // compare first: a beat leaving now belongs to an earlier request
         if (rsp_valid && !rsp_stall) begin
            seen = '{granted: rsp_granted, id: rsp_grant_id,
                     kind: grant_kind_type'(rsp_grant_kind), last: rsp_last_result};
            if (pending_grants.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected beat granted=%b id=%0d kind=%b last=%b",
                           $time, seen.granted, seen.id, seen.kind, seen.last);
            end else begin
               want = pending_grants.pop_front();
               if (seen.granted !== want.granted || seen.id !== want.id ||
                   seen.kind !== want.kind || seen.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch exp %b/%0d/%b/%b got %b/%0d/%b/%b",
                              $time, want.granted, want.id, want.kind, want.last,
                              seen.granted, seen.id, seen.kind, seen.last);
               end
            end
         end
         if (req_valid && !req_stall)
            predict_grants(req_kind_type'(req_type), req_requester_id);
      end
      mismatches <= mismatch_count;
      outstanding <= pending_grants.size();
      served <= served_count;
   end

endmodule

// ===== test/tb.sv =====
// top of the reader-writer lock arbiter testbench: stimulus, pacing and verdict
`timescale 1ns / 1ps
module tb
   import rwl_pkg::*;
();

   localparam int AGENTS      = 16;
   localparam int HOLD_CYCLES = 300;   // long receiver hold-off
   localparam int PHASE_BEATS = 50;    // served requests per pacing phase

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   logic [1:0]      req_type = REQ_START_READ;
   logic [ID_W-1:0] req_requester_id = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   logic            rsp_granted;
   logic [ID_W-1:0] rsp_grant_id;
   logic            rsp_grant_kind;
   logic            rsp_last_result;

   int mismatches;
   int outstanding;
   int served;

   // pacing knobs: sender idle chance is local to the stimulus process,
   // receiver stall chance and the hold-off request go to the stall process
   int idle_pct = 0;
   int stall_pct = 0;
   logic hold_req = 1'b0;
   logic hold_done = 1'b0;
   int hold_left = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   reader_writer_lock_arbiter #(.AGENT_COUNT(AGENTS)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_requester_id (req_requester_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted      (rsp_granted),
      .rsp_grant_id     (rsp_grant_id),
      .rsp_grant_kind   (rsp_grant_kind),
      .rsp_last_result  (rsp_last_result)
   );

   rwl_checker #(.AGENT_COUNT(AGENTS)) grant_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_requester_id (req_requester_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted      (rsp_granted),
      .rsp_grant_id     (rsp_grant_id),
      .rsp_grant_kind   (rsp_grant_kind),
      .rsp_last_result  (rsp_last_result),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .served           (served)
   );

   // receiver side: a requested hold-off stalls without a break, once per request,
   // otherwise stall at the current random rate
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         hold_done <= 1'b1;
      end else begin
         if (!hold_req)
            hold_done <= 1'b0;
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // one request beat; idle cycles go before it, valid stays up between
   // back-to-back beats
   task automatic send_request(input req_kind_type kind, input logic [ID_W-1:0] id);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_requester_id <= id;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random(input req_kind_type kind);
      send_request(kind, ID_W'($urandom_range(AGENTS - 1)));
   endtask

   // sender holds back until every predicted beat has come out
   task automatic wait_for_grants();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // one random request sequence; most are well formed lock traffic
   task automatic run_sequence();
      int pick;
      int n;
      pick = $urandom_range(9);
      if (pick <= 2) begin
         // writer holds the lock while readers pile up, then one release
         // hands out the whole reader queue (and may overflow it)
         send_random(REQ_START_WRITE);
         n = $urandom_range(1, 18);
         repeat (n) send_random(REQ_START_READ);
         send_random(REQ_END_WRITE);
      end else if (pick <= 4) begin
         // reader holds off a row of writers, which then pass the lock along
         send_random(REQ_START_READ);
         n = $urandom_range(1, 18);
         repeat (n) send_random(REQ_START_WRITE);
         repeat ($urandom_range(1, 4)) send_random(REQ_END_READ);
         repeat (n + 1) send_random(REQ_END_WRITE);
      end else if (pick == 5) begin
         // reader flood, can run the active count into saturation
         n = $urandom_range(20, 36);
         repeat (n) send_random(REQ_START_READ);
         repeat (n) send_random(REQ_END_READ);
      end else if (pick == 6) begin
         // drain whatever is left active
         send_random(REQ_END_WRITE);
         repeat ($urandom_range(1, 34)) send_random(REQ_END_READ);
         send_random(REQ_END_WRITE);
      end else begin
         // noise
         repeat ($urandom_range(1, 6))
            send_random(req_kind_type'($urandom_range(3)));
      end
   endtask

   initial begin
      int waited;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: releases with nothing active, ids at both ends, a write
      // queued behind readers, last reader granting the head writer,
      // write release of queued readers, writer handoff with no readers
      send_request(REQ_END_READ, 4'd3);
      send_request(REQ_END_WRITE, 4'd9);
      send_request(REQ_START_READ, 4'd0);
      send_request(REQ_START_READ, 4'd15);
      send_request(REQ_START_WRITE, 4'd15);
      send_request(REQ_START_WRITE, 4'd1);
      send_request(REQ_END_READ, 4'd0);
      send_request(REQ_END_READ, 4'd15);
      send_request(REQ_START_READ, 4'd7);
      send_request(REQ_START_READ, 4'd8);
      send_request(REQ_START_WRITE, 4'd2);
      send_request(REQ_END_WRITE, 4'd15);
      send_request(REQ_END_READ, 4'd7);
      send_request(REQ_END_READ, 4'd8);
      send_request(REQ_END_WRITE, 4'd1);
      send_request(REQ_START_READ, 4'd4);
      send_request(REQ_END_WRITE, 4'd2);
      send_request(REQ_END_READ, 4'd4);
      send_request(REQ_START_WRITE, 4'd5);
      send_request(REQ_END_WRITE, 4'd5);
      wait_for_grants();

      // random part in four pacing phases: none, sender idle, receiver
      // stall with a long hold-off first, both
      for (int pace = 0; pace < 4; pace++) begin
         case (pace)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 46; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 46; hold_req <= 1'b1; end
            default: begin idle_pct = 38; stall_pct <= 38; end
         endcase
         while (served < 18 + PHASE_BEATS * (pace + 1))
            run_sequence();
         hold_req <= 1'b0;
         wait_for_grants();
      end

      // drain, then keep the clock running to catch stray beats
      req_valid <= 1'b0;
      stall_pct <= 0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (outstanding != 0 && waited < 200000);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #5000000;
      $display("FAILURE");
      $finish;
   end

endmodule
